@@ design/frdf_pkg.sv @@
// ----------------------------------------------------------------------------
// frdf_pkg
// Shared types and constants of the flood relay duplicate filter.
// ----------------------------------------------------------------------------
package frdf_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int ID_W   = 16;
  localparam int LIFE_W = 4;
  localparam int MODE_W = 2;
  localparam int CFG_W  = 8;
  localparam int ADDR_W = 2;

  localparam logic [MODE_W-1:0] MODE_RELAY     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ORIGINATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GATEWAY   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ACK_CHECK = 2'd3;

  localparam logic [ADDR_W-1:0] CFG_NODE_ID        = 2'd0;
  localparam logic [ADDR_W-1:0] CFG_END_NODE_COUNT = 2'd1;
  localparam logic [ADDR_W-1:0] CFG_MAX_SENT_COUNT = 2'd2;
  localparam logic [ADDR_W-1:0] CFG_LIFESPAN_LIMIT = 2'd3;

  localparam logic [7:0]        NODE_ID_RST        = 8'd1;
  localparam logic [7:0]        END_NODE_COUNT_RST = 8'd16;
  localparam logic [7:0]        MAX_SENT_COUNT_RST = 8'd100;
  localparam logic [LIFE_W-1:0] LIFESPAN_LIMIT_RST = 4'd3;

  // search probe moving down the cell row
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            hit;
    logic            acked;
  } probe_t;

  // write command broadcast to all cells
  typedef struct packed {
    logic            store;
    logic            set_ack;
    logic [ID_W-1:0] id;
    logic            acked;
  } wcmd_t;

endpackage

@@ design/frdf_cell.sv @@
// ----------------------------------------------------------------------------
// frdf_cell
// One table entry: compares the passing probe against its ID and registers the
// probe before handing it on to the next cell.
// ----------------------------------------------------------------------------
module frdf_cell #(
  parameter int SLOT_W     = 4,
  parameter int CELL_INDEX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  frdf_pkg::probe_t     probe_in,
  input  logic [SLOT_W-1:0]    slot_in,
  output frdf_pkg::probe_t     probe_out,
  output logic [SLOT_W-1:0]    slot_out,
  input  frdf_pkg::wcmd_t      wcmd,
  input  logic [SLOT_W-1:0]    wslot
);
  import frdf_pkg::*;

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_INDEX);

  logic [ID_W-1:0] entry_id;
  logic            entry_valid;
  logic            entry_acked;
  logic            match;
  logic            selected;

  assign selected = (wslot == MY_SLOT);
  assign match    = !probe_in.hit && entry_valid && (entry_id == probe_in.id);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      entry_acked <= 1'b0;
    end else if (wcmd.store && selected) begin
      entry_valid <= 1'b1;
      entry_acked <= wcmd.acked;
    end else if (wcmd.set_ack && selected) begin
      entry_acked <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wcmd.store && selected) begin
      entry_id <= wcmd.id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.hit <= 1'b0;
    end else begin
      probe_out.hit <= probe_in.hit | match;
    end
    probe_out.id    <= probe_in.id;
    probe_out.acked <= match ? entry_acked : probe_in.acked;
    slot_out        <= match ? MY_SLOT : slot_in;
  end

endmodule

@@ design/frdf_ctrl.sv @@
// ----------------------------------------------------------------------------
// frdf_ctrl
// Sequencer: takes a beat, waits for the probe to cross the cell row, then
// decides the result, issues the table update and holds the result beat.
// ----------------------------------------------------------------------------
module frdf_ctrl #(
  parameter int DEPTH  = frdf_pkg::TABLE_DEPTH_DEF,
  parameter int SLOT_W = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [frdf_pkg::ADDR_W-1:0]     cfg_addr,
  input  logic [frdf_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [frdf_pkg::MODE_W-1:0]     in_mode,
  input  logic                            in_ack,
  input  logic [frdf_pkg::LIFE_W-1:0]     in_life,
  input  logic [frdf_pkg::ID_W-1:0]       in_id,
  output frdf_pkg::probe_t                probe_head,
  input  frdf_pkg::probe_t                probe_tail,
  input  logic [SLOT_W-1:0]               slot_tail,
  output frdf_pkg::wcmd_t                 wcmd,
  output logic [SLOT_W-1:0]               wslot,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_forward,
  output logic                            out_ack,
  output logic [frdf_pkg::LIFE_W-1:0]     out_life,
  output logic [frdf_pkg::ID_W-1:0]       out_id,
  output logic                            out_acknowledged
);
  import frdf_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

  logic [1:0]        state;
  logic [SLOT_W-1:0] cnt;
  logic [SLOT_W-1:0] write_slot;
  logic [7:0]        sent_count;
  logic [7:0]        node_id;
  logic [7:0]        end_node_count;
  logic [7:0]        max_sent_count;
  logic [LIFE_W-1:0] lifespan_limit;

  logic [MODE_W-1:0] item_mode;
  logic              item_ack;
  logic [LIFE_W-1:0] item_life;
  logic [ID_W-1:0]   item_id;

  logic              fire;
  logic              fwd_next;
  logic              ack_next;
  logic [LIFE_W-1:0] life_next;
  logic [ID_W-1:0]   id_next;
  logic              acknowledged_next;
  logic              store;
  logic              set_ack;
  logic              store_acked;
  logic [ID_W-1:0]   store_id;
  logic [ID_W-1:0]   gen_id;
  logic [LIFE_W:0]   life_inc;
  logic [7:0]        sent_inc;
  logic [7:0]        sent_next;

  assign in_ready = (state == S_IDLE);
  assign fire     = (state == S_DECIDE) && (!out_valid || out_ready);

  assign probe_head.id    = item_id;
  assign probe_head.hit   = 1'b0;
  assign probe_head.acked = 1'b0;

  assign gen_id   = ID_W'({8'd0, end_node_count} * {8'd0, sent_count}) + ID_W'(node_id);
  assign life_inc = {1'b0, item_life} + (LIFE_W+1)'(1);
  assign sent_inc = sent_count + 8'd1;
  assign sent_next = (sent_inc > max_sent_count) ? 8'd0 : sent_inc;

  always_comb begin
    fwd_next          = 1'b0;
    ack_next          = 1'b0;
    life_next         = '0;
    id_next           = '0;
    acknowledged_next = 1'b0;
    store             = 1'b0;
    set_ack           = 1'b0;
    store_acked       = 1'b0;
    store_id          = item_id;
    unique case (item_mode)
      MODE_RELAY: begin
        if (item_life < lifespan_limit) begin
          if (probe_tail.hit) begin
            if (item_ack && !probe_tail.acked) begin
              set_ack  = 1'b1;
              fwd_next = 1'b1;
            end
          end else begin
            store       = 1'b1;
            store_acked = item_ack;
            fwd_next    = 1'b1;
          end
          if (fwd_next) begin
            ack_next  = item_ack;
            life_next = life_inc[LIFE_W] ? {LIFE_W{1'b1}} : life_inc[LIFE_W-1:0];
            id_next   = item_id;
          end
        end
      end
      MODE_ORIGINATE: begin
        store    = 1'b1;
        store_id = gen_id;
        fwd_next = 1'b1;
        id_next  = gen_id;
      end
      MODE_GATEWAY: begin
        if (!probe_tail.hit) begin
          store    = 1'b1;
          fwd_next = 1'b1;
          ack_next = 1'b1;
          id_next  = item_id;
        end
      end
      MODE_ACK_CHECK: begin
        acknowledged_next = probe_tail.hit && item_ack;
      end
      default: begin
      end
    endcase
  end

  assign wcmd.store   = fire && store;
  assign wcmd.set_ack = fire && set_ack;
  assign wcmd.id      = store_id;
  assign wcmd.acked   = store_acked;
  assign wslot        = set_ack ? slot_tail : write_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      write_slot <= '0;
      sent_count <= 8'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SEARCH;
            cnt   <= '0;
          end
        end
        S_SEARCH: begin
          if (cnt == LAST_SLOT) begin
            state <= S_DECIDE;
          end else begin
            cnt <= cnt + SLOT_W'(1);
          end
        end
        S_DECIDE: begin
          if (fire) begin
            state <= S_IDLE;
            if (store) begin
              write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + SLOT_W'(1);
            end
            if (item_mode == MODE_ORIGINATE) begin
              sent_count <= sent_next;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_mode <= in_mode;
      item_ack  <= in_ack;
      item_life <= in_life;
      item_id   <= in_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id        <= NODE_ID_RST;
      end_node_count <= END_NODE_COUNT_RST;
      max_sent_count <= MAX_SENT_COUNT_RST;
      lifespan_limit <= LIFESPAN_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_NODE_ID:        node_id        <= cfg_wdata;
        CFG_END_NODE_COUNT: end_node_count <= cfg_wdata;
        CFG_MAX_SENT_COUNT: max_sent_count <= cfg_wdata;
        CFG_LIFESPAN_LIMIT: lifespan_limit <= cfg_wdata[LIFE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_forward      <= fwd_next;
      out_ack          <= ack_next;
      out_life         <= life_next;
      out_id           <= id_next;
      out_acknowledged <= acknowledged_next;
    end
  end

endmodule

@@ design/flood_relay_duplicate_filter.sv @@
// ----------------------------------------------------------------------------
// flood_relay_duplicate_filter
// Duplicate filter for a flooding mesh over a row of seen-ID cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one frame per beat (mode, ack flag, hop count, message ID).
//   m_axis returns exactly one result beat per input beat, in order.
//   cfg_we/cfg_addr/cfg_wdata write the four settings while the block is idle.
// Timing:
//   An accepted beat sends a probe down the TABLE_DEPTH cells, one cell per
//   cycle, then the result is decided and the table updated in the same cycle.
//   Only one beat is in flight: a new beat is taken only once the last one has
//   been decided. The result beat is registered and held on m_axis.
// Stalls:
//   The result register holds while m_tready is low; the next input beat is
//   still taken and searched, and waits to decide until the result is gone.
// Reset:
//   rst clears all entry valid and ack bits, the ring pointer, the sent count
//   and loads the default settings. No clearing pass is needed.
// ----------------------------------------------------------------------------
module flood_relay_duplicate_filter #(
  parameter int TABLE_DEPTH = frdf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [frdf_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [frdf_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // lifespan_in[3:0], message_id[19:4]
  input  logic [2:0]                  s_axis_tuser,  // mode[1:0], ack_in[2]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,  // forward[0], lifespan_out[4:1],
                                                     // id_out[20:5], acknowledged[21]
  output logic                        m_axis_tuser   // ack_out[0]
);
  import frdf_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_DEPTH);

  probe_t            probe_chain [TABLE_DEPTH+1];
  logic [SLOT_W-1:0] slot_chain  [TABLE_DEPTH+1];
  wcmd_t             wcmd;
  logic [SLOT_W-1:0] wslot;

  logic              out_forward;
  logic              out_ack;
  logic [LIFE_W-1:0] out_life;
  logic [ID_W-1:0]   out_id;
  logic              out_acknowledged;

  assign slot_chain[0] = '0;

  frdf_ctrl #(
    .DEPTH  (TABLE_DEPTH),
    .SLOT_W (SLOT_W)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (s_axis_tvalid),
    .in_ready         (s_axis_tready),
    .in_mode          (s_axis_tuser[1:0]),
    .in_ack           (s_axis_tuser[2]),
    .in_life          (s_axis_tdata[3:0]),
    .in_id            (s_axis_tdata[19:4]),
    .probe_head       (probe_chain[0]),
    .probe_tail       (probe_chain[TABLE_DEPTH]),
    .slot_tail        (slot_chain[TABLE_DEPTH]),
    .wcmd             (wcmd),
    .wslot            (wslot),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_forward      (out_forward),
    .out_ack          (out_ack),
    .out_life         (out_life),
    .out_id           (out_id),
    .out_acknowledged (out_acknowledged)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    frdf_cell #(
      .SLOT_W     (SLOT_W),
      .CELL_INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_in  (probe_chain[i]),
      .slot_in   (slot_chain[i]),
      .probe_out (probe_chain[i+1]),
      .slot_out  (slot_chain[i+1]),
      .wcmd      (wcmd),
      .wslot     (wslot)
    );
  end

  assign m_axis_tdata = {2'b00, out_acknowledged, out_id, out_life, out_forward};
  assign m_axis_tuser = out_ack;

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  a_quiet_when_dropped: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !out_forward |-> !out_ack && out_life == '0 && out_id == '0)
    else $error("frame fields set on a dropped result");

  a_ack_check_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_acknowledged |-> !out_forward)
    else $error("ack check result together with a broadcast");

  a_no_write_in_search: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> !(wcmd.store && wcmd.set_ack))
    else $error("store and ack update in the same cycle");
`endif

endmodule

@@ tb/flood_relay_duplicate_filter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flood_relay_duplicate_filter_tb
// Self-checking bench for the flood relay duplicate filter. A scripted opening
// covers every mode, hop limits, repeats, ack marking and originate ID build;
// random frames under several settings follow. A model of the seen-ID ring
// predicts the result beats not typed into the script; all are compared field
// by field in order. Both stream sides idle at random, and the result side
// holds off once for a long stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
module flood_relay_duplicate_filter_tb;
  import frdf_pkg::*;

  localparam int DEPTH          = TABLE_DEPTH_DEF;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 24;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 150;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int STALL_LIMIT    = 3000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              ack;
    logic [LIFE_W-1:0] life;
    logic [ID_W-1:0]   id;
  } frame_t;

  typedef struct packed {
    logic              fwd;
    logic              ack;
    logic [LIFE_W-1:0] life;
    logic [ID_W-1:0]   id;
    logic              acked;
  } verdict_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              ack;
    logic [LIFE_W-1:0] life;
    logic [ID_W-1:0]   id;
    logic              typed;
    logic              fwd;
    logic              ack_o;
    logic [LIFE_W-1:0] life_o;
    logic [ID_W-1:0]   id_o;
    logic              acked;
  } script_row_t;

  logic              clk;
  logic              rst           = 1'b1;
  logic              cfg_we        = 1'b0;
  logic [ADDR_W-1:0] cfg_addr      = '0;
  logic [CFG_W-1:0]  cfg_wdata     = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata  = '0;
  logic [2:0]        s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;
  logic              m_axis_tuser;

  // model of the seen-ID ring and settings
  logic [ID_W-1:0]   seen_id_q [DEPTH];
  bit                seen_ok   [DEPTH];
  bit                seen_ack  [DEPTH];
  int unsigned       ring_slot;
  logic [7:0]        sent_q;
  logic [7:0]        node_id_cfg;
  logic [7:0]        end_nodes_cfg;
  logic [7:0]        max_sent_cfg;
  logic [LIFE_W-1:0] hop_limit_cfg;

  verdict_t pending_verdicts[$];
  int       mismatches  = 0;
  bit       steady_send = 1'b0;
  bit       squeeze_req = 1'b0;

  // t=1 rows carry the result typed in; the rest use the model
  script_row_t script [25] = '{
    '{MODE_RELAY,     1'b0, 4'd0, 16'h0000, 1'b1, 1'b1, 1'b0, 4'd1, 16'h0000, 1'b0},
    '{MODE_RELAY,     1'b0, 4'd0, 16'h0000, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0},
    '{MODE_RELAY,     1'b1, 4'd1, 16'h0000, 1'b1, 1'b1, 1'b1, 4'd2, 16'h0000, 1'b0},
    '{MODE_RELAY,     1'b1, 4'd1, 16'h0000, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0},
    '{MODE_RELAY,     1'b1, 4'd2, 16'hFFFF, 1'b1, 1'b1, 1'b1, 4'd3, 16'hFFFF, 1'b0},
    '{MODE_RELAY,     1'b1, 4'd0, 16'hFFFF, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0},
    '{MODE_RELAY,     1'b0, 4'd3, 16'h1234, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0},
    '{MODE_RELAY,     1'b1, 4'd9, 16'hABCD, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0},
    '{MODE_ORIGINATE, 1'b1, 4'd9, 16'hFFFF, 1'b1, 1'b1, 1'b0, 4'd0, 16'd1,    1'b0},
    '{MODE_ORIGINATE, 1'b0, 4'd0, 16'h0000, 1'b1, 1'b1, 1'b0, 4'd0, 16'd17,   1'b0},
    '{MODE_RELAY,     1'b0, 4'd0, 16'd17,   1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0},
    '{MODE_GATEWAY,   1'b0, 4'd0, 16'h5555, 1'b1, 1'b1, 1'b1, 4'd0, 16'h5555, 1'b0},
    '{MODE_GATEWAY,   1'b0, 4'd0, 16'h5555, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0},
    '{MODE_GATEWAY,   1'b1, 4'd9, 16'h0000, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0},
    '{MODE_ACK_CHECK, 1'b1, 4'd0, 16'h0000, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b1},
    '{MODE_ACK_CHECK, 1'b0, 4'd0, 16'h0000, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0},
    '{MODE_ACK_CHECK, 1'b1, 4'd0, 16'h2222, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0},
    '{MODE_RELAY,     1'b1, 4'd0, 16'h5555, 1'b1, 1'b1, 1'b1, 4'd1, 16'h5555, 1'b0},
    '{MODE_ORIGINATE, 1'b0, 4'd0, 16'hFFFF, 1'b1, 1'b1, 1'b0, 4'd0, 16'd33,   1'b0},
    // relay stores 49, originate stores it again: first slot decides
    '{MODE_RELAY,     1'b0, 4'd0, 16'd49,   1'b0, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0},
    '{MODE_ORIGINATE, 1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0},
    '{MODE_RELAY,     1'b1, 4'd0, 16'd49,   1'b0, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0},
    '{MODE_RELAY,     1'b1, 4'd0, 16'd49,   1'b0, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0},
    // dropped frames are never stored
    '{MODE_ACK_CHECK, 1'b1, 4'd9, 16'h1234, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0},
    '{MODE_ACK_CHECK, 1'b1, 4'd8, 16'hABCD, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0000, 1'b0}
  };

  flood_relay_duplicate_filter #(
    .TABLE_DEPTH (DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int lookup_slot(input logic [ID_W-1:0] id);
    for (int i = 0; i < DEPTH; i++) begin
      if (seen_ok[i] && seen_id_q[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void remember(input logic [ID_W-1:0] id, input bit acked);
    seen_id_q[ring_slot] = id;
    seen_ok[ring_slot]   = 1'b1;
    seen_ack[ring_slot]  = acked;
    ring_slot = (ring_slot + 1) % DEPTH;
  endfunction

  function automatic verdict_t filter_frame(input frame_t f);
    verdict_t    v;
    int          slot;
    int unsigned gen;
    logic [7:0]  nxt;
    v = '0;
    case (f.mode)
      MODE_RELAY: begin
        if (f.life < hop_limit_cfg) begin
          slot = lookup_slot(f.id);
          if (slot >= 0) begin
            if (f.ack && !seen_ack[slot]) begin
              seen_ack[slot] = 1'b1;
              v.fwd = 1'b1;
            end
          end else begin
            remember(f.id, f.ack);
            v.fwd = 1'b1;
          end
          if (v.fwd) begin
            v.ack  = f.ack;
            v.life = (f.life == 4'd15) ? 4'd15 : f.life + 4'd1;
            v.id   = f.id;
          end
        end
      end
      MODE_ORIGINATE: begin
        gen = int'(end_nodes_cfg) * int'(sent_q) + int'(node_id_cfg);
        remember(gen[ID_W-1:0], 1'b0);
        nxt = sent_q + 8'd1;
        if (nxt > max_sent_cfg) nxt = 8'd0;
        sent_q = nxt;
        v.fwd  = 1'b1;
        v.id   = gen[ID_W-1:0];
      end
      MODE_GATEWAY: begin
        if (lookup_slot(f.id) < 0) begin
          remember(f.id, 1'b0);
          v.fwd = 1'b1;
          v.ack = 1'b1;
          v.id  = f.id;
        end
      end
      default: begin
        v.acked = (lookup_slot(f.id) >= 0) && f.ack;
      end
    endcase
    return v;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic frame_t draw_frame();
    frame_t f;
    int     r;
    int     slot;
    r = $urandom_range(0, 99);
    if (r < 45)      f.mode = MODE_RELAY;
    else if (r < 60) f.mode = MODE_ORIGINATE;
    else if (r < 75) f.mode = MODE_GATEWAY;
    else             f.mode = MODE_ACK_CHECK;
    f.ack = 1'($urandom_range(0, 1));
    if (hop_limit_cfg != 0 && $urandom_range(0, 3) != 0)
      f.life = LIFE_W'($urandom_range(0, int'(hop_limit_cfg) - 1));
    else
      f.life = LIFE_W'($urandom_range(0, 9));
    // bias toward IDs already in the ring so repeats and acks get exercised
    r    = $urandom_range(0, 99);
    slot = $urandom_range(0, DEPTH - 1);
    if (r < 35 && seen_ok[slot]) f.id = seen_id_q[slot];
    else if (r < 70)             f.id = ID_W'($urandom_range(0, 31));
    else                         f.id = ID_W'($urandom_range(0, 65535));
    return f;
  endfunction

  task automatic report_mismatch(input string field, input logic [ID_W-1:0] got,
                                 input logic [ID_W-1:0] want);
    $display("%0t: %s mismatch: got %0h, want %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  task automatic offer_frame(input frame_t f, input bit typed, input verdict_t v);
    int       gap;
    verdict_t want;
    gap = steady_send ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, f.id, f.life};
    s_axis_tuser  <= {f.ack, f.mode};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    want = filter_frame(f);
    pending_verdicts.push_back(typed ? v : want);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] node, input logic [7:0] endc,
                                input logic [7:0] maxs, input logic [LIFE_W-1:0] hops);
    logic [ADDR_W-1:0] regs [4];
    logic [CFG_W-1:0]  vals [4];
    regs = '{CFG_NODE_ID, CFG_END_NODE_COUNT, CFG_MAX_SENT_COUNT, CFG_LIFESPAN_LIMIT};
    vals = '{node, endc, maxs, {4'b0, hops}};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we        <= 1'b0;
    node_id_cfg   = node;
    end_nodes_cfg = endc;
    max_sent_cfg  = maxs;
    hop_limit_cfg = hops;
  endtask

  // result side: random holds, calm stretches, one long squeeze on request
  initial begin : sink
    int hold;
    int calm;
    bit squeezed;
    hold     = 0;
    calm     = 0;
    squeezed = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        hold = SQUEEZE_CYCLES;
        calm = 0;
      end
      if (hold == 0 && calm == 0 && $urandom_range(0, 49) == 0)
        calm = $urandom_range(40, 160);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else if (calm > 0) begin
        m_axis_tready <= 1'b1;
        calm--;
      end else begin
        hold = idle_len();
        m_axis_tready <= (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  always @(posedge clk) begin : result_check
    verdict_t got;
    verdict_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.fwd   = m_axis_tdata[0];
      got.life  = m_axis_tdata[4:1];
      got.id    = m_axis_tdata[20:5];
      got.acked = m_axis_tdata[21];
      got.ack   = m_axis_tuser;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata[15:0], '0);
      end else begin
        want = pending_verdicts.pop_front();
        if (got.fwd !== want.fwd)
          report_mismatch("forward", ID_W'(got.fwd), ID_W'(want.fwd));
        if (got.ack !== want.ack)
          report_mismatch("ack_out", ID_W'(got.ack), ID_W'(want.ack));
        if (got.life !== want.life)
          report_mismatch("lifespan_out", ID_W'(got.life), ID_W'(want.life));
        if (got.id !== want.id)
          report_mismatch("id_out", got.id, want.id);
        if (got.acked !== want.acked)
          report_mismatch("acknowledged", ID_W'(got.acked), ID_W'(want.acked));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    frame_t            f;
    verdict_t          v;
    logic [7:0]        nd;
    logic [7:0]        en;
    logic [7:0]        mx;
    logic [LIFE_W-1:0] lim;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      seen_id_q[i] = '0;
      seen_ok[i]   = 1'b0;
      seen_ack[i]  = 1'b0;
    end
    ring_slot     = 0;
    sent_q        = 8'd0;
    node_id_cfg   = NODE_ID_RST;
    end_nodes_cfg = END_NODE_COUNT_RST;
    max_sent_cfg  = MAX_SENT_COUNT_RST;
    hop_limit_cfg = LIFESPAN_LIMIT_RST;

    foreach (script[i]) begin
      f = '{script[i].mode, script[i].ack, script[i].life, script[i].id};
      v = '{script[i].fwd, script[i].ack_o, script[i].life_o, script[i].id_o,
            script[i].acked};
      offer_frame(f, script[i].typed, v);
    end
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        // low extremes; max below the current count forces a wrap
        0: begin nd = 8'd0;   en = 8'd1;   mx = 8'd0;   lim = 4'd1; end
        1: begin nd = 8'd255; en = 8'd255; mx = 8'd254; lim = 4'd9; end
        // zero hop limit: relay drops everything
        2: begin nd = 8'd7;   en = 8'd3;   mx = 8'd5;   lim = 4'd0; end
        default: begin
          nd  = 8'($urandom_range(0, 255));
          en  = 8'($urandom_range(1, 255));
          mx  = 8'($urandom_range(0, 254));
          lim = LIFE_W'($urandom_range(1, 9));
        end
      endcase
      apply_settings(nd, en, mx, lim);
      steady_send = (ph % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == 5) squeeze_req = 1'b1;
        offer_frame(draw_frame(), 1'b0, '0);
      end
      settle();
    end

    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
